// File: rtl/power_on_beam_pixel_shader_top_macros.svh
// ----------------------------------------------------------------------------
// Power-on beam pixel shader: assertion macros
// Shared concurrent assertion shorthands, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef POWER_ON_BEAM_PIXEL_SHADER_TOP_MACROS_SVH
`define POWER_ON_BEAM_PIXEL_SHADER_TOP_MACROS_SVH

// Same-cycle implication
`define POBPS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define POBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pobps_pkg.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader package
// Field widths, register indexes, shading constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package pobps_pkg;

	// Field widths
	localparam int COORD_W    = 6;
	localparam int TIME_W     = 32;
	localparam int COLOR_W    = 8;
	localparam int DIM_W      = 7;
	localparam int HEAD_W     = 7;
	localparam int YF_W       = 15;
	localparam int FLICK_W    = 7;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_PROGRESS   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_W    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_H    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BASE_HUE   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BASE_SAT   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PEAK_VALUE = 3'd5;

	// Reset values
	localparam logic [DIM_W-1:0]   RST_FRAME_DIM = 7'd16;
	localparam logic [COLOR_W-1:0] RST_BASE_SAT  = 8'd255;
	localparam logic [COLOR_W-1:0] RST_PEAK      = 8'd255;

	// Shading constants
	localparam logic [7:0] FULL_SCALE  = 8'd255;
	localparam logic [7:0] NEAR_SCALE  = 8'd180;
	localparam logic [7:0] FAR_SCALE   = 8'd90;
	localparam logic [4:0] GAIN_STEP   = 5'd22;
	localparam logic [7:0] GAIN_FLOOR  = 8'd160;
	localparam logic [7:0] GAIN_KNEE   = FULL_SCALE - GAIN_FLOOR;
	localparam int         FLICK_KX    = 37;
	localparam int         FLICK_KY    = 53;
	localparam int         FLICK_STEP  = 6;

	// Reciprocals: x/255 for x < 2^15, x/3 for x < 2^8
	localparam int RECIP_255   = 257;
	localparam int RECIP_SHIFT = 16;
	localparam int THIRD_RECIP = 171;
	localparam int THIRD_SHIFT = 9;

	typedef struct packed {
		logic [7:0]         progress;
		logic [DIM_W-1:0]   frame_width;
		logic [DIM_W-1:0]   frame_height;
		logic [COLOR_W-1:0] base_hue;
		logic [COLOR_W-1:0] base_saturation;
		logic [COLOR_W-1:0] peak_value;
	} cfg_t;

	// Geometry beat handed from the geometry stages to the shading stages
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               in_frame;
		logic [HEAD_W-1:0]  head;
		logic [7:0]         rem;
		logic [7:0]         gain;
		logic [FLICK_W-1:0] flick;
	} geo_t;

endpackage

`default_nettype wire

// File: rtl/pobps_ifs.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader channels
// Valid/ready channels for pixel beats in and shaded pixel beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pobps_pix_if;
	import pobps_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [TIME_W-1:0]  time_ms;
	modport source (output valid, pixel_x, pixel_y, time_ms, input ready);
	modport sink   (input valid, pixel_x, pixel_y, time_ms, output ready);
endinterface

interface pobps_res_if;
	import pobps_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic [COLOR_W-1:0] out_hue;
	logic [COLOR_W-1:0] out_saturation;
	logic [COLOR_W-1:0] out_value;
	logic               write_pixel;
	modport source (output valid, out_x, out_y, out_hue, out_saturation, out_value,
		write_pixel, input ready);
	modport sink   (input valid, out_x, out_y, out_hue, out_saturation, out_value,
		write_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/pobps_cfg.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader: configuration registers
// APB-style register file holding progress, frame size, colour and peak.
// ----------------------------------------------------------------------------
`default_nettype none

module pobps_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [pobps_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [pobps_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [pobps_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                      pready,
	output pobps_pkg::cfg_t                           cfg
);
	import pobps_pkg::*;

	logic [7:0]         progress_q;
	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	logic [COLOR_W-1:0] base_hue_q;
	logic [COLOR_W-1:0] base_sat_q;
	logic [COLOR_W-1:0] peak_q;
	logic [REG_IDX_W-1:0] idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	// Write decode; unknown indexes drop the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q     <= '0;
			frame_width_q  <= RST_FRAME_DIM;
			frame_height_q <= RST_FRAME_DIM;
			base_hue_q     <= '0;
			base_sat_q     <= RST_BASE_SAT;
			peak_q         <= RST_PEAK;
		end else if (wr_en) begin
			case (idx)
				REG_PROGRESS:   progress_q     <= pwdata[7:0];
				REG_FRAME_W:    frame_width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_H:    frame_height_q <= pwdata[DIM_W-1:0];
				REG_BASE_HUE:   base_hue_q     <= pwdata[COLOR_W-1:0];
				REG_BASE_SAT:   base_sat_q     <= pwdata[COLOR_W-1:0];
				REG_PEAK_VALUE: peak_q         <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_PROGRESS:   prdata = APB_DATA_W'(progress_q);
			REG_FRAME_W:    prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_H:    prdata = APB_DATA_W'(frame_height_q);
			REG_BASE_HUE:   prdata = APB_DATA_W'(base_hue_q);
			REG_BASE_SAT:   prdata = APB_DATA_W'(base_sat_q);
			REG_PEAK_VALUE: prdata = APB_DATA_W'(peak_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.progress        = progress_q;
	assign cfg.frame_width     = frame_width_q;
	assign cfg.frame_height    = frame_height_q;
	assign cfg.base_hue        = base_hue_q;
	assign cfg.base_saturation = base_sat_q;
	assign cfg.peak_value      = peak_q;

endmodule

`default_nettype wire

// File: rtl/pobps_geom.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader: geometry stages
// Stage 1 clamps the frame, tests the pixel, forms the head product and the
// column offset. Stage 2 divides by 255, forms the centre gain and flicker.
// ----------------------------------------------------------------------------
`default_nettype none
`include "power_on_beam_pixel_shader_top_macros.svh"

module pobps_geom #(
	parameter int unsigned MAX_DIM = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pobps_pkg::cfg_t cfg,
	pobps_pix_if.sink            pix,
	output logic                 geo_valid,
	input  wire logic            geo_ready,
	output pobps_pkg::geo_t      geo
);
	import pobps_pkg::*;

	localparam int PROD_W = YF_W + 9;

	// Stage 1
	logic [DIM_W-1:0]   w_eff, h_eff, h_m1;
	logic [COORD_W-1:0] mid, dx_c;
	logic [7:0]         inv_p;
	logic               inside_c;
	logic [YF_W-1:0]    yf_c;
	logic [3:0]         fidx_c;

	logic               v_s1, en_s1;
	logic [COORD_W-1:0] x_s1, y_s1, dx_s1;
	logic               inside_s1;
	logic [YF_W-1:0]    yf_s1;
	logic [3:0]         fidx_s1;

	// Stage 2
	logic [PROD_W-1:0]  prod;
	logic [HEAD_W-1:0]  head_est, head_c;
	logic [YF_W-1:0]    rem0;
	logic [7:0]         rem_c, gain_c;
	logic [10:0]        dx22;
	logic [FLICK_W-1:0] flick_c;

	logic               v_s2, en_s2;
	geo_t               geo_s2;

	// Clamp frame size to 1..MAX_DIM
	always_comb begin
		w_eff = cfg.frame_width;
		if (cfg.frame_width == '0)
			w_eff = DIM_W'(1);
		else if (32'(cfg.frame_width) > MAX_DIM)
			w_eff = DIM_W'(MAX_DIM);
		h_eff = cfg.frame_height;
		if (cfg.frame_height == '0)
			h_eff = DIM_W'(1);
		else if (32'(cfg.frame_height) > MAX_DIM)
			h_eff = DIM_W'(MAX_DIM);
	end

	// Stage 1 arithmetic
	always_comb begin
		inside_c = ({1'b0, pix.pixel_x} < w_eff) && ({1'b0, pix.pixel_y} < h_eff);
		mid      = w_eff[DIM_W-1:1];
		dx_c     = (pix.pixel_x >= mid) ? (pix.pixel_x - mid) : (mid - pix.pixel_x);
		h_m1     = h_eff - DIM_W'(1);
		inv_p    = FULL_SCALE - cfg.progress;
		yf_c     = YF_W'(h_m1) * YF_W'(inv_p);
		// only the low nibble of the flicker sum survives the mask
		fidx_c   = 4'(4'(pix.pixel_x) * 4'(FLICK_KX) + 4'(pix.pixel_y) * 4'(FLICK_KY)
			+ pix.time_ms[5:2]);
	end

	// Stage handshake: a stage advances when empty or when its successor advances
	assign en_s2     = !v_s2 || geo_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign pix.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1      <= pix.pixel_x;
			y_s1      <= pix.pixel_y;
			dx_s1     <= dx_c;
			inside_s1 <= inside_c;
			yf_s1     <= yf_c;
			fidx_s1   <= fidx_c;
		end
	end

	// Divide by 255: reciprocal estimate, then one correction step
	always_comb begin
		prod     = PROD_W'(yf_s1) * PROD_W'(RECIP_255);
		head_est = HEAD_W'(prod >> RECIP_SHIFT);
		rem0     = yf_s1 - YF_W'(head_est) * YF_W'(FULL_SCALE);
		if (rem0 >= YF_W'(FULL_SCALE)) begin
			head_c = head_est + HEAD_W'(1);
			rem_c  = 8'(rem0 - YF_W'(FULL_SCALE));
		end else begin
			head_c = head_est;
			rem_c  = 8'(rem0);
		end
	end

	// Centre gain with floor, and flicker step
	always_comb begin
		dx22    = 11'(dx_s1) * 11'(GAIN_STEP);
		gain_c  = (dx22 >= 11'(GAIN_KNEE)) ? GAIN_FLOOR : 8'(11'(FULL_SCALE) - dx22);
		flick_c = FLICK_W'(fidx_s1) * FLICK_W'(FLICK_STEP);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			geo_s2.x        <= x_s1;
			geo_s2.y        <= y_s1;
			geo_s2.in_frame <= inside_s1;
			geo_s2.head     <= head_c;
			geo_s2.rem      <= rem_c;
			geo_s2.gain     <= gain_c;
			geo_s2.flick    <= flick_c;
		end
	end

	assign geo_valid = v_s2;
	assign geo       = geo_s2;

	`POBPS_ASSERT(a_rem_range, v_s2, geo_s2.rem < FULL_SCALE, "remainder not below 255")
	`POBPS_ASSERT(a_gain_floor, v_s2, geo_s2.gain >= GAIN_FLOOR, "centre gain below floor")
	`POBPS_ASSERT_NEXT(a_div_exact, en_s2 && v_s1,
		YF_W'(geo_s2.head) * YF_W'(FULL_SCALE) + YF_W'(geo_s2.rem) == $past(yf_s1),
		"divide by 255 does not reproduce the dividend")

endmodule

`default_nettype wire

// File: rtl/pobps_shade.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader: shading stages
// Stage 3 picks the row value from the head distance. Stage 4 applies the
// centre gain, adds flicker with saturation and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "power_on_beam_pixel_shader_top_macros.svh"

module pobps_shade (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pobps_pkg::cfg_t cfg,
	input  wire logic            geo_valid,
	output logic                 geo_ready,
	input  wire pobps_pkg::geo_t geo,
	pobps_res_if.source          res
);
	import pobps_pkg::*;

	function automatic logic [7:0] sc8(input logic [7:0] a, input logic [7:0] b);
		logic [16:0] p;
		p = 17'(a) * (17'(b) + 17'd1);
		return p[15:8];
	endfunction

	function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	// Stage 3
	logic [HEAD_W-1:0]  y7, row_dist;
	logic [7:0]         near_c, far_c, third_c, row_c;
	logic [15:0]        third_p;

	logic               v_s3, en_s3;
	logic [COORD_W-1:0] x_s3, y_s3;
	logic               inside_s3;
	logic [7:0]         row_s3, gain_s3;
	logic [FLICK_W-1:0] flick_s3;

	// Stage 4
	logic [7:0]         value_c;

	logic               v_s4, en_s4;
	logic [COORD_W-1:0] x_s4, y_s4;
	logic [7:0]         value_s4;
	logic               wr_s4;

	// Row value from distance to the head
	always_comb begin
		y7       = HEAD_W'(geo.y);
		row_dist = (y7 >= geo.head) ? (y7 - geo.head) : (geo.head - y7);
		near_c   = sc8(cfg.peak_value, NEAR_SCALE);
		far_c    = sc8(cfg.peak_value, FAR_SCALE);
		third_p  = 16'(geo.rem) * 16'(THIRD_RECIP);
		third_c  = 8'(third_p >> THIRD_SHIFT);
		case (row_dist)
			7'd0:    row_c = cfg.peak_value;
			7'd1:    row_c = (geo.rem != '0) ? sat_add8(near_c, third_c) : near_c;
			7'd2:    row_c = far_c;
			default: row_c = '0;
		endcase
	end

	// Stage handshake
	assign en_s4     = !v_s4 || res.ready;
	assign en_s3     = !v_s3 || en_s4;
	assign geo_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= geo_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3      <= geo.x;
			y_s3      <= geo.y;
			inside_s3 <= geo.in_frame;
			row_s3    <= row_c;
			gain_s3   <= geo.gain;
			flick_s3  <= geo.flick;
		end
	end

	// Apply gain, add flicker, blank pixels outside the frame
	always_comb begin
		value_c = sat_add8(sc8(row_s3, gain_s3), 8'(flick_s3));
		if (!inside_s3)
			value_c = '0;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			x_s4     <= x_s3;
			y_s4     <= y_s3;
			value_s4 <= value_c;
			wr_s4    <= (value_c != '0);
		end
	end

	assign res.valid          = v_s4;
	assign res.out_x          = x_s4;
	assign res.out_y          = y_s4;
	assign res.out_hue        = cfg.base_hue;
	assign res.out_saturation = cfg.base_saturation;
	assign res.out_value      = value_s4;
	assign res.write_pixel    = wr_s4;

	`POBPS_ASSERT_NEXT(a_outside_dark, en_s4 && v_s3 && !inside_s3,
		!res.write_pixel && (res.out_value == '0), "pixel outside frame was lit")
	`POBPS_ASSERT_NEXT(a_row_lit, en_s4 && v_s3 && inside_s3 && (row_s3 >= 8'd2),
		res.write_pixel, "lit row gave a dark pixel")
	`POBPS_ASSERT_NEXT(a_flick_floor, en_s4 && v_s3 && inside_s3,
		res.out_value >= 8'($past(flick_s3)), "flicker add lost its floor")

endmodule

`default_nettype wire

// File: rtl/power_on_beam_pixel_shader_top.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader
// Per-pixel brightness for a rising beam with trailing glow and flicker.
// ----------------------------------------------------------------------------
// The block takes one pixel beat (column, row, millisecond time) per clock while
// the result side is ready, and returns one shaded beat per pixel, in order.
// The four register stages are frame test and head product, divide by 255
// with centre gain, row selection, and gain multiply with saturating flicker
// add; each stage moves on as soon as the one after it is free, so a waiting
// result holds back new pixels only once all four stages carry a beat, and
// pixel ready follows result ready within the same cycle. Hue and saturation
// come straight from the registers, which are to be written only while no
// pixel is in flight.
`default_nettype none

module power_on_beam_pixel_shader_top #(
	parameter int unsigned MAX_DIM = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	pobps_pix_if.sink                                 pix,
	pobps_res_if.source                               res,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [pobps_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [pobps_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [pobps_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                      pready
);
	import pobps_pkg::*;

	cfg_t cfg;
	geo_t geo;
	logic geo_valid;
	logic geo_ready;

	pobps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pobps_geom #(
		.MAX_DIM (MAX_DIM)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix       (pix),
		.geo_valid (geo_valid),
		.geo_ready (geo_ready),
		.geo       (geo)
	);

	pobps_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.geo_valid (geo_valid),
		.geo_ready (geo_ready),
		.geo       (geo),
		.res       (res)
	);

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Power-on beam pixel shader testbench
// Drives pixel beats over the valid/ready channel and programs the registers
// through the APB port. Every accepted pixel is shaded by a local predictor,
// and each result beat is compared field by field, in order. A short table of
// directed pixels and register writes comes first. Random phases follow, each
// with its own frame setting, random gaps on both channels in all but two
// phases, one long result stall in one phase and one full drain in another.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pobps_pkg::*;

	localparam int unsigned MAX_DIM     = 64;
	localparam int          N_DIR       = 31;
	localparam int          N_PHASE     = 12;
	localparam int          PHASE_ITEMS = 100;
	localparam int          DRAIN_CYC   = 8;
	localparam int          LONG_HOLD   = 300;
	localparam int          MAX_GAP     = 13;

	// Register slots past the last real one; writes there must be ignored
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] hue;
		logic [COLOR_W-1:0] sat;
		logic [COLOR_W-1:0] value;
		logic               wr;
	} shade_t;

	typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

	// Pixel rows: a = column, b = row. Register rows: a = index, b = value.
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [31:0] t;
		logic        fixed;
		logic [7:0]  val;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	pobps_pix_if pix ();
	pobps_res_if res ();

	power_on_beam_pixel_shader_top #(
		.MAX_DIM(MAX_DIM)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	cfg_t        regs;
	shade_t      shade_q[$];
	int unsigned fail_cnt = 0;
	bit          idle_on  = 1'b1;
	int unsigned hold_req = 0;

	dir_row_t dir_tab [N_DIR] = '{
		// reset setting: head on the bottom row, centre column at full gain
		'{ROW_PIX, 8'd8,  8'd15, 32'h0000_0000, 1'b1, 8'd255},
		// pixels outside the frame
		'{ROW_PIX, 8'd16, 8'd0,  32'h0000_0000, 1'b1, 8'd0},
		'{ROW_PIX, 8'd0,  8'd16, 32'hFFFF_FFFF, 1'b1, 8'd0},
		'{ROW_PIX, 8'd63, 8'd63, 32'hFFFF_FFFF, 1'b1, 8'd0},
		// far from the head: flicker alone, none and full
		'{ROW_PIX, 8'd0,  8'd0,  32'h0000_0000, 1'b1, 8'd0},
		'{ROW_PIX, 8'd0,  8'd0,  32'hFFFF_FFFF, 1'b1, 8'd90},
		'{ROW_PIX, 8'd15, 8'd14, 32'h1234_5678, 1'b0, 8'd0},
		'{ROW_PIX, 8'd8,  8'd13, 32'h0000_0005, 1'b0, 8'd0},
		// head on the top row
		'{ROW_CFG, 8'(REG_PROGRESS), 8'd255, 32'h0, 1'b0, 8'd0},
		'{ROW_PIX, 8'd8,  8'd0,  32'h0000_0000, 1'b1, 8'd255},
		'{ROW_PIX, 8'd8,  8'd1,  32'h0000_0003, 1'b0, 8'd0},
		'{ROW_PIX, 8'd8,  8'd2,  32'h0000_0007, 1'b0, 8'd0},
		// zero width is taken as one column
		'{ROW_CFG, 8'(REG_FRAME_W), 8'd0, 32'h0, 1'b0, 8'd0},
		'{ROW_PIX, 8'd0,  8'd3,  32'h8000_0001, 1'b0, 8'd0},
		'{ROW_PIX, 8'd1,  8'd0,  32'h0000_0000, 1'b1, 8'd0},
		// oversized height, head part way up with a remainder
		'{ROW_CFG, 8'(REG_FRAME_H), 8'd127, 32'h0, 1'b0, 8'd0},
		'{ROW_CFG, 8'(REG_PROGRESS), 8'd100, 32'h0, 1'b0, 8'd0},
		'{ROW_PIX, 8'd0,  8'd37, 32'h0000_0010, 1'b0, 8'd0},
		'{ROW_PIX, 8'd0,  8'd39, 32'hDEAD_BEEF, 1'b0, 8'd0},
		'{ROW_PIX, 8'd0,  8'd63, 32'h0000_0000, 1'b0, 8'd0},
		// oversized width
		'{ROW_CFG, 8'(REG_FRAME_W), 8'd127, 32'h0, 1'b0, 8'd0},
		'{ROW_PIX, 8'd63, 8'd38, 32'h0F0F_0F0F, 1'b0, 8'd0},
		'{ROW_PIX, 8'd32, 8'd36, 32'h0000_0004, 1'b0, 8'd0},
		// dark head: nothing but flicker
		'{ROW_CFG, 8'(REG_PEAK_VALUE), 8'd0, 32'h0, 1'b0, 8'd0},
		'{ROW_PIX, 8'd0,  8'd0,  32'h0000_0000, 1'b1, 8'd0},
		// colour pass-through and writes to unused slots
		'{ROW_CFG, 8'(REG_BASE_HUE), 8'd255, 32'h0, 1'b0, 8'd0},
		'{ROW_CFG, 8'(REG_BASE_SAT), 8'd0, 32'h0, 1'b0, 8'd0},
		'{ROW_CFG, 8'(REG_SPARE_A), 8'hAB, 32'h0, 1'b0, 8'd0},
		'{ROW_CFG, 8'(REG_SPARE_B), 8'h55, 32'h0, 1'b0, 8'd0},
		'{ROW_CFG, 8'(REG_PEAK_VALUE), 8'd128, 32'h0, 1'b0, 8'd0},
		'{ROW_PIX, 8'd32, 8'd38, 32'hFFFF_FFF0, 1'b0, 8'd0}
	};

	// Clock: 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] d);
		if (d == 0) return 1;
		if (d > MAX_DIM) return MAX_DIM;
		return d;
	endfunction

	function automatic int unsigned scale8(input int unsigned a, input int unsigned b);
		return ((a & 255) * ((b & 255) + 1)) >> 8;
	endfunction

	// Shade one pixel from the current register copy
	function automatic shade_t shade_pixel(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [TIME_W-1:0] t);
		int unsigned w, h, yf, head, rem, d, row, mid, dx, gain, v, flick;
		shade_t r;
		w = eff_dim(regs.frame_width);
		h = eff_dim(regs.frame_height);
		v = 0;
		if (x < w && y < h) begin
			yf   = (h - 1) * (255 - regs.progress);
			head = yf / 255;
			rem  = yf % 255;
			d    = (y >= head) ? y - head : head - y;
			case (d)
				0: row = regs.peak_value;
				1: begin
					row = scale8(regs.peak_value, 180);
					if (rem > 0) row = (row + rem / 3 > 255) ? 255 : row + rem / 3;
				end
				2: row = scale8(regs.peak_value, 90);
				default: row = 0;
			endcase
			mid   = w / 2;
			dx    = (x >= mid) ? x - mid : mid - x;
			gain  = (dx * 22 >= 95) ? 160 : 255 - dx * 22;
			v     = scale8(row, gain);
			flick = ((x * 37 + y * 53 + (t >> 2)) & 32'h0F) * 6;
			v     = (v + flick > 255) ? 255 : v + flick;
		end
		r.x     = x;
		r.y     = y;
		r.hue   = regs.base_hue;
		r.sat   = regs.base_saturation;
		r.value = v[7:0];
		r.wr    = (v != 0);
		return r;
	endfunction

	function automatic logic [31:0] reg_readback(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_PROGRESS:   return 32'(regs.progress);
			REG_FRAME_W:    return 32'(regs.frame_width);
			REG_FRAME_H:    return 32'(regs.frame_height);
			REG_BASE_HUE:   return 32'(regs.base_hue);
			REG_BASE_SAT:   return 32'(regs.base_saturation);
			REG_PEAK_VALUE: return 32'(regs.peak_value);
			default:        return '0;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 12) return DIM_W'($urandom_range(MAX_DIM + 1, 127));
		return DIM_W'($urandom_range(1, MAX_DIM));
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		fail_cnt++;
	endtask

	// One APB transfer: setup, then access until pready
	task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [31:0] data, output logic [31:0] rd);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (wr) begin
			case (idx)
				REG_PROGRESS:   regs.progress        = data[7:0];
				REG_FRAME_W:    regs.frame_width     = data[DIM_W-1:0];
				REG_FRAME_H:    regs.frame_height    = data[DIM_W-1:0];
				REG_BASE_HUE:   regs.base_hue        = data[7:0];
				REG_BASE_SAT:   regs.base_saturation = data[7:0];
				REG_PEAK_VALUE: regs.peak_value      = data[7:0];
				default: ;
			endcase
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic read_check(input logic [REG_IDX_W-1:0] idx);
		logic [31:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== reg_readback(idx)) report($sformatf("register %0d readback", idx),
			reg_readback(idx), rd);
	endtask

	// Write a register with junk above its field, then read back any real register
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
		logic [31:0] rd;
		apb_xfer(1'b1, idx, ($urandom & 32'hFFFF_FF00) | 32'(val), rd);
		if (idx <= REG_PEAK_VALUE) read_check(idx);
	endtask

	// Drop valid and let the pipe empty before touching registers
	task automatic wait_idle();
		pix.valid = 1'b0;
		do @(negedge clk); while (shade_q.size() != 0);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	// Offer one pixel beat after a random gap; log its shade on acceptance
	task automatic push_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [TIME_W-1:0] t, input logic fixed, input logic [7:0] fval);
		int unsigned gap;
		shade_t e;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			pix.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid   = 1'b1;
		pix.pixel_x = x;
		pix.pixel_y = y;
		pix.time_ms = t;
		do @(posedge clk); while (!pix.ready);
		e = shade_pixel(x, y, t);
		if (fixed) begin
			e.value = fval;
			e.wr    = (fval != 0);
		end
		shade_q.push_back(e);
		@(negedge clk);
	endtask

	// Result side: random wait per beat, plus one long hold on request
	initial begin : res_side
		int unsigned res_wait;
		int unsigned n;
		res_wait  = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				res.ready = 1'b0;
				n         = hold_req;
				hold_req  = 0;
				repeat (n) @(negedge clk);
			end
			if (res_wait != 0) begin
				res.ready = 1'b0;
				res_wait--;
			end else begin
				res.ready = 1'b1;
			end
			@(posedge clk);
			if (arst_n && res.valid && res.ready)
				res_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	// Compare each result beat with the oldest logged shade
	always @(posedge clk) begin : res_check
		shade_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.out_x, res.out_y, res.out_hue, res.out_saturation, res.out_value,
				res.write_pixel};
			if (shade_q.size() == 0) begin
				$display("%0t ns: result beat with none expected, expected nothing, got %h",
					$time, got);
				fail_cnt++;
			end else begin
				want = shade_q.pop_front();
				if (got.x !== want.x) report("out_x", want.x, got.x);
				if (got.y !== want.y) report("out_y", want.y, got.y);
				if (got.hue !== want.hue) report("out_hue", want.hue, got.hue);
				if (got.sat !== want.sat) report("out_saturation", want.sat, got.sat);
				if (got.value !== want.value) report("out_value", want.value, got.value);
				if (got.wr !== want.wr) report("write_pixel", want.wr, got.wr);
			end
		end
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	initial begin : stim
		int unsigned w, h, hd;
		int          yy;
		int unsigned r;
		logic [COORD_W-1:0] px, py;
		logic [7:0] v_prog, v_hue, v_sat, v_peak;
		logic [DIM_W-1:0] v_w, v_h;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pix.valid   = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		pix.time_ms = '0;
		regs = '{progress: 8'd0, frame_width: RST_FRAME_DIM, frame_height: RST_FRAME_DIM,
			base_hue: 8'd0, base_saturation: RST_BASE_SAT, peak_value: RST_PEAK};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values
		for (logic [REG_IDX_W:0] i = REG_PROGRESS; i <= REG_PEAK_VALUE; i++)
			read_check(i[REG_IDX_W-1:0]);

		// Directed table
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_tab[i].a[REG_IDX_W-1:0], dir_tab[i].b);
			end else begin
				push_pixel(dir_tab[i].a[COORD_W-1:0], dir_tab[i].b[COORD_W-1:0], dir_tab[i].t,
					dir_tab[i].fixed, dir_tab[i].val);
			end
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < N_PHASE; ph++) begin
			case (ph)
				0: begin
					v_prog = 8'd0; v_w = 7'd1; v_h = 7'd1;
					v_hue = 8'd0; v_sat = 8'd0; v_peak = 8'd0;
				end
				1: begin
					v_prog = 8'd255; v_w = 7'd64; v_h = 7'd64;
					v_hue = 8'd255; v_sat = 8'd255; v_peak = 8'd255;
				end
				2: begin
					v_prog = 8'($urandom); v_w = 7'd127; v_h = 7'd0;
					v_hue = 8'($urandom); v_sat = 8'($urandom); v_peak = 8'($urandom);
				end
				default: begin
					v_prog = 8'($urandom); v_w = pick_dim(); v_h = pick_dim();
					v_hue = 8'($urandom); v_sat = 8'($urandom);
					v_peak = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
				end
			endcase
			wait_idle();
			write_reg(REG_PROGRESS, v_prog);
			write_reg(REG_FRAME_W, 8'(v_w));
			write_reg(REG_FRAME_H, 8'(v_h));
			write_reg(REG_BASE_HUE, v_hue);
			write_reg(REG_BASE_SAT, v_sat);
			write_reg(REG_PEAK_VALUE, v_peak);
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
			idle_on = !(ph == 4 || ph == 8);

			w  = eff_dim(regs.frame_width);
			h  = eff_dim(regs.frame_height);
			hd = ((h - 1) * (255 - regs.progress)) / 255;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Stall the result side while pixels keep coming
				if (ph == 3 && k == 10) hold_req = LONG_HOLD;
				// Hold the pixel side until every result is back
				if (ph == 5 && k == 50) begin
					pix.valid = 1'b0;
					do @(negedge clk); while (shade_q.size() != 0);
				end
				px = ($urandom_range(0, 99) < 85) ? COORD_W'($urandom_range(0, w - 1))
					: COORD_W'($urandom);
				r = $urandom_range(0, 99);
				if (r < 50) begin
					// rows around the head, where the glow lives
					yy = int'(hd) + int'($urandom_range(0, 6)) - 3;
					if (yy < 0) yy = 0;
					if (yy > int'(h) - 1) yy = int'(h) - 1;
					py = COORD_W'(yy);
				end else if (r < 85) begin
					py = COORD_W'($urandom_range(0, h - 1));
				end else begin
					py = COORD_W'($urandom);
				end
				push_pixel(px, py, $urandom, 1'b0, 8'd0);
			end
		end

		// Drain and finish
		pix.valid = 1'b0;
		do @(negedge clk); while (shade_q.size() != 0);
		repeat (DRAIN_CYC) @(negedge clk);
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
